/* design/bqw_pkg.sv */
// Shared types and constants for the Birks quenching weight block.
// No dependencies; imported by the top level, the checker and the testbench.
package bqw_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_ENABLE       = 3'd0;
	localparam logic [2:0] REG_SCINT_KB     = 3'd1;
	localparam logic [2:0] REG_SCINT_QUAD   = 3'd2;
	localparam logic [2:0] REG_SCINT_ALPHA  = 3'd3;
	localparam logic [2:0] REG_CRYST_KB     = 3'd4;
	localparam logic [2:0] REG_CRYST_QUAD   = 3'd5;
	localparam logic [2:0] REG_CRYST_ALPHA  = 3'd6;

	// Register reset values
	localparam logic [31:0] RST_SCINT_KB    = 32'd872415;
	localparam logic [31:0] RST_SCINT_QUAD  = 32'd2382365;
	localparam logic [31:0] RST_SCINT_ALPHA = 32'd29360128;
	localparam logic [31:0] RST_CRYST_KB    = 32'd5591846;
	localparam logic [31:0] RST_CRYST_QUAD  = 32'd0;
	localparam logic [31:0] RST_CRYST_ALPHA = 32'd16777216;

	// Fixed-point constants
	localparam logic [31:0] ONE_Q24   = 32'd16777216;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	// Per-item flags carried down the pipe
	typedef struct packed {
		logic mag2;   // |charge| >= 2
		logic scint;  // scintillator coefficient set
		logic pass;   // weight forced to 1.0
		logic zero;   // zero deposit
		logic ovf;    // weight saturates to 0
	} bqw_flags_t;

endpackage

/* design/bqw_div_cell.sv */
// One restoring-division step with its own registers.
// Depends on nothing; instantiated by bqw_div_chain.
module bqw_div_cell #(
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SB = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] nq_i,
	input  logic [DW-1:0] dv_i,
	input  logic [SB-1:0] sb_i,
	output logic          v_o,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] nq_o,
	output logic [DW-1:0] dv_o,
	output logic [SB-1:0] sb_o
);

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;
	logic          v_q;
	logic [DW-1:0] rem_q;
	logic [QW-1:0] nq_q;
	logic [DW-1:0] dv_q;
	logic [SB-1:0] sb_q;

	// shift in the next dividend bit, subtract when it fits
	assign trial = {rem_i, nq_i[QW-1]};
	assign diff  = trial - {1'b0, dv_i};
	assign ge    = trial >= {1'b0, dv_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nq_q  <= {nq_i[QW-2:0], ge};
			dv_q  <= dv_i;
			sb_q  <= sb_i;
		end
	end

	assign v_o   = v_q;
	assign rem_o = rem_q;
	assign nq_o  = nq_q;
	assign dv_o  = dv_q;
	assign sb_o  = sb_q;

endmodule

/* design/bqw_div_chain.sv */
// Row of division cells, one quotient bit per cell, one beat per cycle while en is high.
// Depends on bqw_div_cell.
module bqw_div_chain #(
	parameter int DW = 32,
	parameter int QW = 32,
	parameter int SB = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] nq_i,
	input  logic [DW-1:0] dv_i,
	input  logic [SB-1:0] sb_i,
	output logic          v_o,
	output logic [QW-1:0] q_o,
	output logic [SB-1:0] sb_o
);

	logic [QW:0]         v_w;
	logic [QW:0][DW-1:0] rem_w;
	logic [QW:0][QW-1:0] nq_w;
	logic [QW:0][DW-1:0] dv_w;
	logic [QW:0][SB-1:0] sb_w;

	assign v_w[0]   = v_i;
	assign rem_w[0] = rem_i;
	assign nq_w[0]  = nq_i;
	assign dv_w[0]  = dv_i;
	assign sb_w[0]  = sb_i;

	for (genvar i = 0; i < QW; i++) begin : g_cell
		bqw_div_cell #(.DW(DW), .QW(QW), .SB(SB)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.v_i   (v_w[i]),
			.rem_i (rem_w[i]),
			.nq_i  (nq_w[i]),
			.dv_i  (dv_w[i]),
			.sb_i  (sb_w[i]),
			.v_o   (v_w[i+1]),
			.rem_o (rem_w[i+1]),
			.nq_o  (nq_w[i+1]),
			.dv_o  (dv_w[i+1]),
			.sb_o  (sb_w[i+1])
		);
	end

	assign v_o  = v_w[QW];
	assign q_o  = nq_w[QW];
	assign sb_o = sb_w[QW];

endmodule

/* design/birks_quenching_weight.sv */
// Top level of the Birks quenching weight pipeline.
// Depends on bqw_pkg and bqw_div_chain.
//
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | energy_deposit, step_length, particle_charge,
//          |                        | material_density, is_scintillator
//  out     | out_valid / out_stall  | accepted, quench_weight, quenched_energy
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat enters per cycle unless the pipe holds; each passes in order through:
// 48 cells for dE/dx and rkb, 6 multiply stages, 42 cells for the alpha divide,
// one sum stage, 17 cells for the reciprocal and the output register.
// Reset clears valid bits and loads register defaults; cfg_ready is always high.
// The whole pipe holds while the output beat is stalled.
module birks_quenching_weight (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] energy_deposit,
	input  logic [31:0] step_length,
	input  logic signed [7:0] particle_charge,
	input  logic [20:0] material_density,
	input  logic        is_scintillator,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [16:0] quench_weight,
	output logic [31:0] quenched_energy,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	import bqw_pkg::*;

	localparam int SBA = 32 + 42 + 42 + $bits(bqw_flags_t);
	localparam int SBF = 32 + $bits(bqw_flags_t);

	logic        enable_q;
	logic [31:0] scint_kb_q, scint_quad_q, scint_alpha_q;
	logic [31:0] cryst_kb_q, cryst_quad_q, cryst_alpha_q;
	logic        adv;
	logic        out_vld_q;
	bqw_flags_t  f_in;

	// config writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			scint_kb_q    <= RST_SCINT_KB;
			scint_quad_q  <= RST_SCINT_QUAD;
			scint_alpha_q <= RST_SCINT_ALPHA;
			cryst_kb_q    <= RST_CRYST_KB;
			cryst_quad_q  <= RST_CRYST_QUAD;
			cryst_alpha_q <= RST_CRYST_ALPHA;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_SCINT_KB:    scint_kb_q    <= cfg_data;
				REG_SCINT_QUAD:  scint_quad_q  <= cfg_data;
				REG_SCINT_ALPHA: scint_alpha_q <= cfg_data;
				REG_CRYST_KB:    cryst_kb_q    <= cfg_data;
				REG_CRYST_QUAD:  cryst_quad_q  <= cfg_data;
				REG_CRYST_ALPHA: cryst_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe moves whenever the output register is free or drained
	assign adv      = !out_vld_q || !out_stall;
	assign in_stall = !adv;

	// input flags
	always_comb begin
		f_in.mag2  = (particle_charge > 8'sd1) || (particle_charge < -8'sd1);
		f_in.scint = is_scintillator;
		f_in.pass  = !(enable_q && (particle_charge != 8'sd0) && (step_length != 32'd0));
		f_in.zero  = (energy_deposit == 32'd0);
		f_in.ovf   = (material_density == 21'd0);
	end

	// rkb = kb*2^16/density and dedx = e*2^16/length, side by side
	logic        v_rkb, v_ddx;
	logic [47:0] rkb_w, dedx_w;
	bqw_flags_t  f_d;
	logic [31:0] e_d;

	bqw_div_chain #(.DW(21), .QW(48), .SB($bits(bqw_flags_t))) u_div_rkb (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_i(in_valid),
		.rem_i(21'd0),
		.nq_i({(is_scintillator ? scint_kb_q : cryst_kb_q), 16'd0}),
		.dv_i(material_density), .sb_i(f_in),
		.v_o(v_rkb), .q_o(rkb_w), .sb_o(f_d)
	);

	bqw_div_chain #(.DW(32), .QW(48), .SB(32)) u_div_ddx (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_i(in_valid),
		.rem_i(32'd0), .nq_i({energy_deposit, 16'd0}),
		.dv_i(step_length), .sb_i(energy_deposit),
		.v_o(v_ddx), .q_o(dedx_w), .sb_o(e_d)
	);

	// stage regs
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [31:0] e_s1, e_s2, e_s3, e_s4, e_s5, e_s6, e_s7;
	bqw_flags_t f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7;
	logic [47:0] pp_hh_s1, pp_hl_s1, pp_lh_s1, pp_ll_s1;
	logic [49:0] x_s2, x_s3, x_s4, x_s5;
	logic [56:0] pq_hi_s3, pq_lo_s3;
	logic [43:0] y_s4;
	logic [46:0] pb_hh_s5, pb_hl_s5, pb_lh_s5, pb_ll_s5;
	logic [31:0] rem_s6, dv_s6;
	logic [41:0] nq_s6, b_s6, alow_s6;
	logic [43:0] d_s7;

	logic [95:0] prod_x;
	logic [81:0] prod_y;
	logic [93:0] prod_b;
	logic [31:0] quad_sel, alpha_sel, dv_a;
	logic        ovf_a;

	// x = rkb*dedx/2^16, saturated at 2^50 (a is then past its limit)
	assign prod_x = {pp_hh_s1, 48'd0} + (96'(pp_hl_s1) << 24) + (96'(pp_lh_s1) << 24)
		+ 96'(pp_ll_s1);
	// y = quad*x/2^24, saturated at 2^44 (b is then past its limit)
	assign quad_sel = f_s2.scint ? scint_quad_q : cryst_quad_q;
	assign prod_y   = {pq_hi_s3, 25'd0} + 82'(pq_lo_s3);
	// b = y*x/2^24
	assign prod_b = {pb_hh_s5, 47'd0} + (94'(pb_hl_s5) << 22) + (94'(pb_lh_s5) << 25)
		+ 94'(pb_ll_s5);
	// alpha divide setup, divisor held at no less than 1.0
	assign alpha_sel = f_s5.scint ? scint_alpha_q : cryst_alpha_q;
	assign dv_a      = (alpha_sel < ONE_Q24) ? ONE_Q24 : alpha_sel;
	assign ovf_a     = f_s5.mag2 ? (x_s5[49:18] >= dv_a) : (x_s5[49:42] != 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_rkb & v_ddx;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// partial products of rkb*dedx
			pp_hh_s1 <= rkb_w[47:24] * dedx_w[47:24];
			pp_hl_s1 <= rkb_w[47:24] * dedx_w[23:0];
			pp_lh_s1 <= rkb_w[23:0] * dedx_w[47:24];
			pp_ll_s1 <= rkb_w[23:0] * dedx_w[23:0];
			e_s1     <= e_d;
			f_s1     <= f_d;
			// x and its overflow
			x_s2     <= prod_x[65:16];
			e_s2     <= e_s1;
			f_s2     <= {f_s1.mag2, f_s1.scint, f_s1.pass, f_s1.zero,
				f_s1.ovf | (prod_x[95:66] != 30'd0)};
			// partial products of quad*x
			pq_hi_s3 <= quad_sel * x_s2[49:25];
			pq_lo_s3 <= quad_sel * x_s2[24:0];
			x_s3     <= x_s2;
			e_s3     <= e_s2;
			f_s3     <= f_s2;
			// y
			y_s4     <= prod_y[67:24];
			x_s4     <= x_s3;
			e_s4     <= e_s3;
			f_s4     <= {f_s3.mag2, f_s3.scint, f_s3.pass, f_s3.zero,
				f_s3.ovf | (prod_y[81:68] != 14'd0)};
			// partial products of y*x
			pb_hh_s5 <= y_s4[43:22] * x_s4[49:25];
			pb_hl_s5 <= y_s4[43:22] * x_s4[24:0];
			pb_lh_s5 <= y_s4[21:0] * x_s4[49:25];
			pb_ll_s5 <= y_s4[21:0] * x_s4[24:0];
			x_s5     <= x_s4;
			e_s5     <= e_s4;
			f_s5     <= f_s4;
			// b, and the start of a = x*2^24/alpha
			b_s6     <= prod_b[65:24];
			alow_s6  <= x_s5[41:0];
			rem_s6   <= f_s5.mag2 ? x_s5[49:18] : 32'd0;
			nq_s6    <= {x_s5[17:0], 24'd0};
			dv_s6    <= dv_a;
			e_s6     <= e_s5;
			f_s6     <= {f_s5.mag2, f_s5.scint, f_s5.pass, f_s5.zero,
				f_s5.ovf | ovf_a | (prod_b[93:66] != 28'd0)};
		end
	end

	// alpha divide
	logic        v_a;
	logic [41:0] qa_w, b_a, alow_a;
	logic [31:0] e_a;
	bqw_flags_t  f_a;

	bqw_div_chain #(.DW(32), .QW(42), .SB(SBA)) u_div_alpha (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_i(v_s6),
		.rem_i(rem_s6), .nq_i(nq_s6), .dv_i(dv_s6),
		.sb_i({e_s6, b_s6, alow_s6, f_s6}),
		.v_o(v_a), .q_o(qa_w), .sb_o({e_a, b_a, alow_a, f_a})
	);

	// denominator D = 1 + a + b
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s7 <= 44'(ONE_Q24) + 44'(f_a.mag2 ? qa_w : alow_a) + 44'(b_a);
			e_s7 <= e_a;
			f_s7 <= f_a;
		end
	end

	// weight = (2^40 + D/2) / D
	logic [43:0] num_w;
	logic        v_f;
	logic [16:0] w_raw;
	logic [31:0] e_f;
	bqw_flags_t  f_f;
	logic [16:0] w_sel;
	logic [48:0] ew;

	assign num_w = (44'd1 << 40) + (d_s7 >> 1);

	bqw_div_chain #(.DW(44), .QW(17), .SB(SBF)) u_div_recip (
		.clk(clk), .arst_n(arst_n), .en(adv), .v_i(v_s7),
		.rem_i({17'd0, num_w[43:17]}), .nq_i(num_w[16:0]), .dv_i(d_s7),
		.sb_i({e_s7, f_s7}),
		.v_o(v_f), .q_o(w_raw), .sb_o({e_f, f_f})
	);

	// final weight and quenched energy
	always_comb begin
		if (f_f.zero) begin
			w_sel = 17'd0;
		end else if (f_f.pass) begin
			w_sel = WEIGHT_ONE;
		end else if (f_f.ovf) begin
			w_sel = 17'd0;
		end else begin
			w_sel = w_raw;
		end
	end
	assign ew = e_f * w_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= v_f;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			accepted        <= !f_f.zero;
			quench_weight   <= w_sel;
			quenched_energy <= ew[47:16];
		end
	end

	assign out_valid = out_vld_q;

endmodule

/* test/bqw_checker.sv */
// Checker for the Birks quenching weight block: mirrors the register file from
// the config channel, predicts each input beat and compares output beats in order.
// Depends on bqw_pkg.
`timescale 1ns / 100ps

module bqw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [31:0] energy_deposit,
	input  logic [31:0] step_length,
	input  logic signed [7:0] particle_charge,
	input  logic [20:0] material_density,
	input  logic        is_scintillator,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        accepted,
	input  logic [16:0] quench_weight,
	input  logic [31:0] quenched_energy,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	import bqw_pkg::*;

	typedef struct packed {
		logic        acc;
		logic [16:0] weight;
		logic [31:0] qe;
	} deposit_result_t;

	deposit_result_t expected_q[$];

	logic        enable;
	logic [31:0] s_kb, s_quad, s_alpha, c_kb, c_quad, c_alpha;

	assign pending = expected_q.size();

	// Birks weight in Q1.16; returns 0 on any saturation
	function automatic logic [16:0] birks_weight(logic [31:0] e, logic [31:0] len,
			logic signed [7:0] chg, logic [20:0] dens, logic [31:0] kb,
			logic [31:0] quad, logic [31:0] alpha);
		logic [127:0] rkb, dedx, x, a, y, b, d, dv, w;
		if (dens == 0)
			return 17'd0;
		rkb  = ({96'd0, kb} << 16) / dens;
		dedx = ({96'd0, e} << 16) / len;
		x = (rkb * dedx) >> 16;
		if (x[127:64] != 0)
			return 17'd0;
		a = x;
		if (chg >= 2 || chg <= -2) begin
			dv = (alpha < ONE_Q24) ? ONE_Q24 : alpha;
			a = (x << 24) / dv;
		end
		y = (quad * x) >> 24;
		if (y[127:64] != 0)
			return 17'd0;
		b = (y * x) >> 24;
		if (b[127:64] != 0 || a >= (128'd1 << 42) || b >= (128'd1 << 42))
			return 17'd0;
		d = ONE_Q24 + a + b;
		w = ((128'd1 << 40) + (d >> 1)) / d;
		return w[16:0];
	endfunction

	function automatic deposit_result_t predict_deposit();
		deposit_result_t r;
		logic [16:0] w;
		logic [63:0] prod;
		w = WEIGHT_ONE;
		if (energy_deposit == 0)
			return '0;
		if (enable && particle_charge != 0 && step_length != 0) begin
			if (is_scintillator)
				w = birks_weight(energy_deposit, step_length, particle_charge,
					material_density, s_kb, s_quad, s_alpha);
			else
				w = birks_weight(energy_deposit, step_length, particle_charge,
					material_density, c_kb, c_quad, c_alpha);
		end
		prod = {32'd0, energy_deposit} * {47'd0, w};
		r.acc = 1'b1;
		r.weight = w;
		r.qe = prod[47:16];
		return r;
	endfunction

	// register mirror
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable <= 1'b0;
			s_kb <= RST_SCINT_KB; s_quad <= RST_SCINT_QUAD; s_alpha <= RST_SCINT_ALPHA;
			c_kb <= RST_CRYST_KB; c_quad <= RST_CRYST_QUAD; c_alpha <= RST_CRYST_ALPHA;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:      enable <= cfg_data[0];
				REG_SCINT_KB:    s_kb <= cfg_data;
				REG_SCINT_QUAD:  s_quad <= cfg_data;
				REG_SCINT_ALPHA: s_alpha <= cfg_data;
				REG_CRYST_KB:    c_kb <= cfg_data;
				REG_CRYST_QUAD:  c_quad <= cfg_data;
				REG_CRYST_ALPHA: c_alpha <= cfg_data;
				default: ;
			endcase
		end
	end

	// predict on input beats, compare on output beats
	always @(posedge clk) begin
		deposit_result_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && !in_stall)
				expected_q.push_back(predict_deposit());
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: output beat with nothing expected: %b %0d %0d", $time,
						accepted, quench_weight, quenched_energy);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r.acc !== accepted || exp_r.weight !== quench_weight
							|| exp_r.qe !== quenched_energy) begin
						$display("%0t: mismatch expected acc=%b w=%0d qe=%0d %s",
							$time, exp_r.acc, exp_r.weight, exp_r.qe, "got");
						$display("%0t:   actual acc=%b w=%0d qe=%0d",
							$time, accepted, quench_weight, quenched_energy);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

/* test/testbench.sv */
// Top of the Birks quenching weight test: clock, reset, stimulus, verdict.
// Depends on bqw_pkg, birks_quenching_weight and bqw_checker.
`timescale 1ns / 100ps

module testbench;
	import bqw_pkg::*;

	localparam int LATENCY = 115;
	localparam int WATCHDOG = 5000;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [31:0] energy_deposit, step_length;
	logic signed [7:0] particle_charge;
	logic [20:0] material_density;
	logic is_scintillator;
	logic accepted;
	logic [16:0] quench_weight;
	logic [31:0] quenched_energy;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	int fail_count, pending;
	int idle_cycles;
	bit hold_off;

	birks_quenching_weight dut (.*);
	bqw_checker chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("birks_quenching_weight test failed");
			$finish;
		end
	end

	// receiver: random stall per beat, one long hold-off on request
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if ($urandom_range(0, 9) < 3) n = 0;
			out_stall <= 1'b1;
			repeat (n) @(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_deposit(logic [31:0] e, logic [31:0] len, logic signed [7:0] chg,
			logic [20:0] dens, logic sc, bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 19) : 0;
		if (gaps && $urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		energy_deposit <= e; step_length <= len; particle_charge <= chg;
		material_density <= dens; is_scintillator <= sc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	// mostly physical magnitudes, sometimes full range
	task automatic random_deposit(bit gaps);
		logic [31:0] e, len;
		logic [20:0] dens;
		case ($urandom_range(0, 3))
			0: begin
				e = $urandom;
				len = $urandom;
			end
			1: begin
				e = $urandom_range(0, 32'h000F_FFFF);
				len = $urandom_range(0, 32'h0003_FFFF);
			end
			default: begin
				e = $urandom_range(1, 32'h00FF_FFFF);
				len = $urandom_range(1, 32'h0010_0000);
			end
		endcase
		if ($urandom_range(0, 19) == 0) e = 0;
		if ($urandom_range(0, 19) == 0) len = 0;
		dens = ($urandom_range(0, 1)) ? 21'($urandom_range(1, 21'h1F_FFFF))
			: 21'($urandom_range(21'h0_8000, 21'h08_0000));
		if ($urandom_range(0, 49) == 0) dens = 0;
		send_deposit(e, len, 8'($urandom), dens, 1'($urandom_range(0, 1)), gaps);
	endtask

	task automatic random_config();
		logic [31:0] v;
		int k;
		for (int i = REG_SCINT_KB; i <= REG_CRYST_ALPHA; i++) begin
			k = $urandom_range(0, 5);
			case (k)
				0: v = 0;
				1: v = 32'hFFFF_FFFF;
				2: v = $urandom;
				default: v = $urandom_range(0, 32'h0800_0000);
			endcase
			write_reg(i[2:0], v);
		end
		write_reg(REG_ENABLE, {31'd0, ($urandom_range(0, 4) != 0)});
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; energy_deposit = 0; step_length = 0; particle_charge = 0;
		material_density = 0; is_scintillator = 0;
		cfg_valid = 1'b0; cfg_index = 0; cfg_data = 0;
		hold_off = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: defaults with quenching off, then on
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd1, 21'h1_0000, 1'b1, 0);
		send_deposit(32'd0, 32'h0001_0000, 8'sd1, 21'h1_0000, 1'b1, 0);
		drain();
		write_reg(REG_ENABLE, 32'd1);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd1, 21'h1_0000, 1'b1, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd1, 21'h1_0000, 1'b0, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd2, 21'h1_0000, 1'b1, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sh80, 21'h1_0000, 1'b1, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd127, 21'h1F_FFFF, 1'b0, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd0, 21'h1_0000, 1'b1, 0);
		send_deposit(32'h0001_0000, 32'd0, -8'sd1, 21'h1_0000, 1'b1, 0);
		send_deposit(32'hFFFF_FFFF, 32'd1, 8'sd1, 21'd1, 1'b1, 0);
		send_deposit(32'hFFFF_FFFF, 32'hFFFF_FFFF, -8'sd3, 21'h1F_FFFF, 1'b0, 0);
		send_deposit(32'd1, 32'hFFFF_FFFF, 8'sd1, 21'd1, 1'b1, 0);
		send_deposit(32'h0001_0000, 32'h0001_0000, 8'sd1, 21'd0, 1'b1, 0);
		send_deposit(32'd0, 32'd0, 8'sd0, 21'd0, 1'b0, 0);
		drain();
		// alpha divisor below 1.0 and extreme coefficients
		write_reg(REG_SCINT_ALPHA, 32'd5);
		write_reg(REG_CRYST_ALPHA, 32'hFFFF_FFFF);
		write_reg(REG_CRYST_QUAD, 32'hFFFF_FFFF);
		write_reg(REG_SCINT_QUAD, 32'd0);
		write_reg(REG_SCINT_KB, 32'hFFFF_FFFF);
		write_reg(REG_CRYST_KB, 32'd0);
		send_deposit(32'h0010_0000, 32'h0001_0000, 8'sd2, 21'h1_0000, 1'b1, 0);
		send_deposit(32'h0010_0000, 32'h0001_0000, -8'sd2, 21'h1_0000, 1'b0, 0);
		send_deposit(32'h0010_0000, 32'h0001_0000, 8'sd1, 21'h1_0000, 1'b1, 0);
		drain();

		// random phases
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			for (int i = 0; i < 150; i++) begin
				if (ph == 3 && i == 10) hold_off = 1;
				random_deposit((ph % 3) != 1);
			end
			drain();
		end

		if (fail_count == 0)
			$display("birks_quenching_weight test passed");
		else
			$display("birks_quenching_weight test failed");
		$finish;
	end

endmodule
